// File: rtl/core/swd_master_transfer_assert.svh
// ---------------------------------------------------------------------------
// SWD host transfer assertion macros
// Concurrent assertion shorthands shared by the SWD transfer RTL.
// ---------------------------------------------------------------------------
`ifndef SWD_MASTER_TRANSFER_ASSERT_SVH
`define SWD_MASTER_TRANSFER_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define SWD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("SWD transfer assertion failed");

// The antecedent implies the consequent in the next cycle.
`define SWD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("SWD transfer assertion failed");

`endif

// File: rtl/core/swdmt_pkg.sv
// ---------------------------------------------------------------------------
// SWD host transfer package
// Field widths, ack codes and status codes of the SWD transfer engine.
// ---------------------------------------------------------------------------
`default_nettype none

package swdmt_pkg;

    // Stream payload widths, padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TURNAROUND = 1'b0,
        CFG_DATA_PHASE = 1'b1
    } cfg_index_t;

    // Phase lengths in SWCLK periods.
    localparam logic [7:0] HDR_LEN    = 8'd8;
    localparam logic [7:0] ACK_LEN    = 8'd3;
    localparam logic [7:0] DATA_LEN   = 8'd32;
    localparam logic [7:0] PARITY_LEN = 8'd1;
    localparam logic [7:0] DUMMY_LEN  = 8'd33;

    // Raw ack values.
    localparam logic [2:0] ACK_OK    = 3'b001;
    localparam logic [2:0] ACK_WAIT  = 3'b010;
    localparam logic [2:0] ACK_FAULT = 3'b100;

    // Reported status codes.
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_WAIT       = 3'd1;
    localparam logic [2:0] ST_FAULT      = 3'd2;
    localparam logic [2:0] ST_PROTOCOL   = 3'd3;
    localparam logic [2:0] ST_PARITY_ERR = 3'd4;

    // Input beat kinds carried on s_tuser.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

endpackage

`default_nettype wire

// File: rtl/core/swd_master_transfer.sv
// ---------------------------------------------------------------------------
// SWD host transfer engine
// Sequences one SWD read or write transfer; each tick in it is one SWCLK period.
// ---------------------------------------------------------------------------
//  Channel  | Direction | Carries
//  s_*      | in        | start beats (request, write word, idle count), tick beats
//  m_*      | out       | one result beat per input beat, tlast on the final tick
//  cfg_*    | in        | register writes (turnaround, dummy data phase)
//
//  One beat per cycle while s_tready is high; its result shows in the next cycle.
//  The phase sequencer and bit counter advance one SWCLK bit per tick beat.
//  s_tready is low only while a result waits and m_tready is low.
//  Reset (aresetn low, synchronous) returns the engine to idle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "swd_master_transfer_assert.svh"

module swd_master_transfer
    import swdmt_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [3:0] request, [35:4] write_data, [43:36] idle_count, [44] swdio_sample
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // [0] req_type
    input  wire logic                  s_tuser,

    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // [0] clock_pulse, [1] swdio_level, [2] swdio_drive, [5:3] status,
    // [8:6] ack_bits, [40:9] read_data, [41] busy_res
    output logic [M_TDATA_W-1:0]       m_tdata,
    // done_res
    output logic                       m_tlast,

    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_HDR     = 4'd1,
        PH_TURN1   = 4'd2,
        PH_ACK     = 4'd3,
        PH_RDATA   = 4'd4,
        PH_RPAR    = 4'd5,
        PH_TURN2   = 4'd6,
        PH_WDATA   = 4'd7,
        PH_WPAR    = 4'd8,
        PH_IDLECYC = 4'd9,
        PH_BACKOFF = 4'd10
    } phase_t;

    // Registers.
    logic [2:0]  turnaround_reg;
    logic        data_phase_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  bit_counter_reg, bit_counter_next;
    logic [31:0] shift_word_reg, shift_word_next;
    logic [7:0]  header_bits_reg, header_bits_next;
    logic [3:0]  held_request_reg, held_request_next;
    logic [7:0]  held_idle_reg, held_idle_next;
    logic [2:0]  ack_reg, ack_next;
    logic        data_parity_reg, data_parity_next;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 m_tlast_reg;

    // Input fields.
    logic        req_type;
    logic [3:0]  in_request;
    logic [31:0] in_write_data;
    logic [7:0]  in_idle_count;
    logic        in_sample;

    assign req_type      = s_tuser;
    assign in_request    = s_tdata[3:0];
    assign in_write_data = s_tdata[35:4];
    assign in_idle_count = s_tdata[43:36];
    assign in_sample     = s_tdata[44];

    // Result fields.
    logic        clk_pulse;
    logic        swdio_level;
    logic        swdio_drive;
    logic        done;
    logic [2:0]  status;
    logic [2:0]  ack_out;
    logic [31:0] read_data;

    logic        s_accept;
    logic        is_read;
    logic [7:0]  bc_dec;
    logic [1:0]  ack_idx;
    phase_t      adv_phase;
    logic [7:0]  adv_count;
    logic [7:0]  ta_len;
    logic [7:0]  backoff_len;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign is_read  = held_request_reg[1];
    assign bc_dec   = (bit_counter_reg == 8'd0) ? 8'd0 : bit_counter_reg - 8'd1;
    assign ack_idx  = 2'd3 - bit_counter_reg[1:0];
    assign ta_len   = {5'd0, turnaround_reg};

    // Bit-level work of the current phase: shifting, sampling and pin levels.
    always_comb begin
        shift_word_next   = shift_word_reg;
        header_bits_next  = header_bits_reg;
        held_request_next = held_request_reg;
        held_idle_next    = held_idle_reg;
        ack_next          = ack_reg;
        data_parity_next  = data_parity_reg;
        clk_pulse         = 1'b0;
        swdio_level       = 1'b0;
        swdio_drive       = 1'b0;

        if (req_type == REQ_START) begin
            if (phase_reg == PH_IDLE) begin
                held_request_next = in_request;
                held_idle_next    = in_idle_count;
                header_bits_next  = {1'b1, 1'b0, ^in_request, in_request, 1'b1};
                shift_word_next   = in_write_data;
                data_parity_next  = ^in_write_data;
                ack_next          = 3'd0;
            end
        end else if (phase_reg == PH_IDLE) begin
            swdio_level = 1'b1;
            swdio_drive = 1'b1;
        end else begin
            clk_pulse = 1'b1;
            case (phase_reg)
                PH_HDR: begin
                    swdio_drive      = 1'b1;
                    swdio_level      = header_bits_reg[0];
                    header_bits_next = {1'b0, header_bits_reg[7:1]};
                end
                PH_ACK: begin
                    if (ack_idx != 2'd3) begin
                        ack_next = ack_reg | (3'({2'd0, in_sample}) << ack_idx);
                    end
                end
                PH_RDATA: begin
                    shift_word_next = {in_sample, shift_word_reg[31:1]};
                end
                PH_RPAR: begin
                    data_parity_next = in_sample;
                end
                PH_WDATA: begin
                    swdio_drive     = 1'b1;
                    swdio_level     = shift_word_reg[0];
                    shift_word_next = {1'b0, shift_word_reg[31:1]};
                end
                PH_WPAR: begin
                    swdio_drive = 1'b1;
                    swdio_level = data_parity_reg;
                end
                PH_IDLECYC: begin
                    swdio_drive = 1'b1;
                    swdio_level = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Back-off length depends on the ack just completed.
    always_comb begin
        if (((ack_next == ACK_WAIT) || (ack_next == ACK_FAULT)) && !data_phase_reg) begin
            backoff_len = ta_len;
        end else begin
            backoff_len = DUMMY_LEN + ta_len;
        end
    end

    // Next phase after the current one ends, skipping phases of zero length.
    always_comb begin
        adv_phase = PH_IDLE;
        adv_count = 8'd0;
        unique case (phase_reg)
            PH_HDR: begin
                if (turnaround_reg != 3'd0) begin
                    adv_phase = PH_TURN1;
                    adv_count = ta_len;
                end else begin
                    adv_phase = PH_ACK;
                    adv_count = ACK_LEN;
                end
            end
            PH_TURN1: begin
                adv_phase = PH_ACK;
                adv_count = ACK_LEN;
            end
            PH_ACK: begin
                if (ack_next == ACK_OK) begin
                    if (is_read) begin
                        adv_phase = PH_RDATA;
                        adv_count = DATA_LEN;
                    end else if (turnaround_reg != 3'd0) begin
                        adv_phase = PH_TURN2;
                        adv_count = ta_len;
                    end else begin
                        adv_phase = PH_WDATA;
                        adv_count = DATA_LEN;
                    end
                end else if (backoff_len != 8'd0) begin
                    adv_phase = PH_BACKOFF;
                    adv_count = backoff_len;
                end
            end
            PH_RDATA: begin
                adv_phase = PH_RPAR;
                adv_count = PARITY_LEN;
            end
            PH_RPAR: begin
                if (turnaround_reg != 3'd0) begin
                    adv_phase = PH_TURN2;
                    adv_count = ta_len;
                end else if (held_idle_reg != 8'd0) begin
                    adv_phase = PH_IDLECYC;
                    adv_count = held_idle_reg;
                end
            end
            PH_TURN2: begin
                if (!is_read) begin
                    adv_phase = PH_WDATA;
                    adv_count = DATA_LEN;
                end else if (held_idle_reg != 8'd0) begin
                    adv_phase = PH_IDLECYC;
                    adv_count = held_idle_reg;
                end
            end
            PH_WDATA: begin
                adv_phase = PH_WPAR;
                adv_count = PARITY_LEN;
            end
            PH_WPAR: begin
                if (held_idle_reg != 8'd0) begin
                    adv_phase = PH_IDLECYC;
                    adv_count = held_idle_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Phase and counter update, end-of-transfer status.
    always_comb begin
        phase_next       = phase_reg;
        bit_counter_next = bit_counter_reg;
        done             = 1'b0;
        status           = ST_OK;
        ack_out          = 3'd0;
        read_data        = 32'd0;

        if (req_type == REQ_START) begin
            if (phase_reg == PH_IDLE) begin
                phase_next       = PH_HDR;
                bit_counter_next = HDR_LEN;
            end
        end else if (phase_reg != PH_IDLE) begin
            bit_counter_next = bc_dec;
            if (bc_dec == 8'd0) begin
                phase_next       = adv_phase;
                bit_counter_next = adv_count;
                if (adv_phase == PH_IDLE) begin
                    done    = 1'b1;
                    ack_out = ack_next;
                    if (ack_next == ACK_OK) begin
                        if (is_read) begin
                            read_data = shift_word_next;
                            if ((^shift_word_next) ^ data_parity_next) begin
                                status = ST_PARITY_ERR;
                            end
                        end
                    end else if (ack_next == ACK_WAIT) begin
                        status = ST_WAIT;
                    end else if (ack_next == ACK_FAULT) begin
                        status = ST_FAULT;
                    end else begin
                        status = ST_PROTOCOL;
                    end
                end
            end
        end
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            turnaround_reg <= 3'd1;
            data_phase_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TURNAROUND: turnaround_reg <= cfg_wdata;
                CFG_DATA_PHASE: data_phase_reg <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Transfer state and result register, updated on every accepted beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            bit_counter_reg  <= 8'd0;
            shift_word_reg   <= 32'd0;
            header_bits_reg  <= 8'd0;
            held_request_reg <= 4'd0;
            held_idle_reg    <= 8'd0;
            ack_reg          <= 3'd0;
            data_parity_reg  <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            m_tdata_reg      <= '0;
            m_tlast_reg      <= 1'b0;
        end else if (s_accept) begin
            phase_reg        <= phase_next;
            bit_counter_reg  <= bit_counter_next;
            shift_word_reg   <= shift_word_next;
            header_bits_reg  <= header_bits_next;
            held_request_reg <= held_request_next;
            held_idle_reg    <= held_idle_next;
            ack_reg          <= ack_next;
            data_parity_reg  <= data_parity_next;
            m_tvalid_reg     <= 1'b1;
            m_tdata_reg      <= {6'd0, (phase_next != PH_IDLE), read_data, ack_out, status,
                                 swdio_drive, swdio_level, clk_pulse};
            m_tlast_reg      <= done;
        end else if (m_tready) begin
            m_tvalid_reg     <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // A completed transfer leaves the engine idle.
    `SWD_ASSERT_SAME(a_done_not_busy, aclk, aresetn, m_tvalid && m_tlast, !m_tdata[41])
    // Status and ack are reported only on the final tick.
    `SWD_ASSERT_SAME(a_status_on_done, aclk, aresetn, m_tvalid && !m_tlast, m_tdata[8:3] == 6'd0)
    // A tick taken during a transfer always drives one SWCLK period.
    `SWD_ASSERT_NEXT(a_tick_clocks, aclk, aresetn,
        s_accept && (s_tuser == REQ_TICK) && (phase_reg != PH_IDLE), m_tvalid && m_tdata[0])
    // The bit counter is cleared whenever the engine rests.
    `SWD_ASSERT_SAME(a_idle_counter, aclk, aresetn, phase_reg == PH_IDLE, bit_counter_reg == 8'd0)

endmodule

`default_nettype wire
